### sv/crw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crw_pkg: shared definitions for the chunk reorder window
// Sizes, opcodes, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package crw_pkg;

    // Window geometry and field sizes kept by the block.
    localparam int unsigned WINDOW      = 16;
    localparam int unsigned HANDLE_BITS = 16;
    localparam int unsigned ID_BITS     = 32;
    localparam int unsigned MAX_RELEASE = 16;

    localparam int unsigned SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_BITS  = (MAX_RELEASE > 1) ? $clog2(MAX_RELEASE) : 1;
    localparam int unsigned CMP_W     = ID_BITS + SLOT_BITS + 1;

    // Port field widths.
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned ID_W      = 32;
    localparam int unsigned PAYLOAD_W = 16;
    localparam int unsigned STATUS_W  = 4;
    localparam int unsigned MEM_W     = HANDLE_BITS + PAYLOAD_W;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_CHUNK  = OPCODE_W'(0);
    localparam logic [OPCODE_W-1:0] OP_STOP   = OPCODE_W'(1);
    localparam logic [OPCODE_W-1:0] OP_CANCEL = OPCODE_W'(2);

    // Outcome of one input item.
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED     = 4'd0,
        ST_STALE        = 4'd1,
        ST_PAST_STOP    = 4'd2,
        ST_DUPLICATE    = 4'd3,
        ST_OUT_OF_WIN   = 4'd4,
        ST_FINISHED     = 4'd5,
        ST_STOP_LATER   = 4'd6,
        ST_STOP_NOW     = 4'd7,
        ST_STOP_IGNORED = 4'd8,
        ST_CANCELLED    = 4'd9
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_REL
    } t_state;

    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [SLOT_BITS-1:0] t_slot;

endpackage

### sv/crw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crw_if: channel interfaces of the chunk reorder window
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------

// Request channel: chunk arrivals, stop requests and cancels.
interface crw_in_if import crw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [ID_W-1:0]      seq_id;
    logic [PAYLOAD_W-1:0] payload_handle;
    logic [PAYLOAD_W-1:0] payload_bytes;

    modport source (output valid, opcode, seq_id, payload_handle, payload_bytes,
                    input ready);
    modport sink   (input valid, opcode, seq_id, payload_handle, payload_bytes,
                    output ready);
endinterface

// Result channel: released chunks and per-item status.
interface crw_out_if import crw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 has_chunk;
    logic [ID_W-1:0]      out_id;
    logic [PAYLOAD_W-1:0] out_handle;
    logic [PAYLOAD_W-1:0] out_bytes;
    logic [STATUS_W-1:0]  status;
    logic                 finished;
    logic                 last;

    modport source (output valid, has_chunk, out_id, out_handle, out_bytes, status,
                    finished, last, input ready);
    modport sink   (input valid, has_chunk, out_id, out_handle, out_bytes, status,
                    finished, last, output ready);
endinterface

### sv/crw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crw_ram: simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module crw_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### sv/chunk_reorder_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reorder_window: in-order release of numbered chunk descriptors
// Stores arriving chunks by id in a window RAM and releases them in id order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  i_in      sink       opcode, seq_id, payload_handle, payload_bytes
//  o_out     source     has_chunk, out_id, out_handle, out_bytes, status,
//                       finished, last
//
//  A request is captured in S_IDLE and evaluated in S_EVAL; an arrival that
//  releases chunks then moves to S_REL, where each release is one read of
//  the window RAM, the next read being issued while the current chunk is
//  written out. Reset clears control state and the slot valid bits.
//  A stall on o_out holds the sequencer in place; one result register sits
//  between the sequencer and the output channel.
//
module chunk_reorder_window import crw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crw_in_if.sink    i_in,
    crw_out_if.source o_out
);

    // Sequencer and window state.
    t_state                 r_state, n_state;
    t_id                    r_next_id, n_next_id;
    t_slot                  r_head, n_head;
    t_id                    r_stop_id, n_stop_id;
    logic                   r_stop_set, n_stop_set;
    logic                   r_done, n_done;
    logic [WINDOW-1:0]      r_slot_valid, n_slot_valid;
    logic                   r_fwd, n_fwd;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    t_status                r_status, n_status;

    // Captured request.
    logic [OPCODE_W-1:0]    r_op, n_op;
    t_id                    r_id, n_id;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [PAYLOAD_W-1:0]   r_bytes, n_bytes;

    // Result register.
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_has, n_out_has;
    logic [ID_W-1:0]        r_out_id, n_out_id;
    logic [PAYLOAD_W-1:0]   r_out_handle, n_out_handle;
    logic [PAYLOAD_W-1:0]   r_out_bytes, n_out_bytes;
    t_status                r_out_status, n_out_status;
    logic                   r_out_finished, n_out_finished;
    logic                   r_out_last, n_out_last;

    // Window RAM ports.
    logic                   w_wr_en;
    logic [MEM_W-1:0]       w_wr_data;
    logic                   w_rd_en;
    t_slot                  w_rd_addr;
    logic [MEM_W-1:0]       w_rd_data;
    logic [MEM_W-1:0]       w_rel_data;

    // Request checks against the window.
    t_id                    w_diff;
    logic                   w_stale;
    logic                   w_past;
    logic                   w_oow;
    logic [SLOT_BITS:0]     w_ins_sum;
    t_slot                  w_ins_slot;
    logic                   w_dup;
    t_id                    w_next_inc;
    t_slot                  w_head_next;
    logic                   w_stop_hit0;
    logic                   w_stop_hit1;
    logic [WINDOW-1:0]      w_purge;
    logic                   w_out_free;

    assign w_diff     = r_id - r_next_id;
    assign w_stale    = r_id < r_next_id;
    assign w_past     = r_stop_set && (r_id >= r_stop_id);
    assign w_oow      = CMP_W'(w_diff) >= CMP_W'(WINDOW);
    assign w_ins_sum  = (SLOT_BITS+1)'(r_head) + (SLOT_BITS+1)'(w_diff);
    assign w_ins_slot = (w_ins_sum >= (SLOT_BITS+1)'(WINDOW))
                      ? SLOT_BITS'(w_ins_sum - (SLOT_BITS+1)'(WINDOW))
                      : SLOT_BITS'(w_ins_sum);
    assign w_dup      = r_slot_valid[w_ins_slot];
    assign w_next_inc = r_next_id + ID_BITS'(1);
    assign w_stop_hit0 = r_stop_set && (r_stop_id <= r_next_id);
    assign w_stop_hit1 = r_stop_set && (r_stop_id <= w_next_inc);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_wr_data  = {r_handle, r_bytes};
    assign w_rel_data = r_fwd ? {r_handle, r_bytes} : w_rd_data;

    // Slot of the id after next_id; the id counter wraps to slot zero.
    always_comb begin
        if (r_next_id == '1) begin
            w_head_next = '0;
        end else if (r_head == SLOT_BITS'(WINDOW - 1)) begin
            w_head_next = '0;
        end else begin
            w_head_next = r_head + SLOT_BITS'(1);
        end
    end

    // Slots holding ids at or beyond a new stop id, by distance from the head.
    always_comb begin
        logic [SLOT_BITS:0] v_off;
        v_off = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if ((SLOT_BITS+1)'(i) >= (SLOT_BITS+1)'(r_head)) begin
                v_off = (SLOT_BITS+1)'(i) - (SLOT_BITS+1)'(r_head);
            end else begin
                v_off = (SLOT_BITS+1)'(i) + (SLOT_BITS+1)'(WINDOW)
                      - (SLOT_BITS+1)'(r_head);
            end
            w_purge[i] = !w_oow && (v_off >= (SLOT_BITS+1)'(w_diff));
        end
    end

    // Window RAM holding handle and byte count of each stored chunk.
    crw_ram #(
        .DEPTH (WINDOW),
        .WIDTH (MEM_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_ins_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state and outputs of the sequencer.
    always_comb begin
        logic    v_single;
        logic    v_insert;
        t_status v_status;

        v_single       = 1'b0;
        v_insert       = 1'b0;
        v_status       = ST_STOP_IGNORED;

        n_state        = r_state;
        n_next_id      = r_next_id;
        n_head         = r_head;
        n_stop_id      = r_stop_id;
        n_stop_set     = r_stop_set;
        n_done         = r_done;
        n_slot_valid   = r_slot_valid;
        n_fwd          = r_fwd;
        n_cnt          = r_cnt;
        n_status       = r_status;
        n_op           = r_op;
        n_id           = r_id;
        n_handle       = r_handle;
        n_bytes        = r_bytes;

        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_has      = r_out_has;
        n_out_id       = r_out_id;
        n_out_handle   = r_out_handle;
        n_out_bytes    = r_out_bytes;
        n_out_status   = r_out_status;
        n_out_finished = r_out_finished;
        n_out_last     = r_out_last;

        w_wr_en        = 1'b0;
        w_rd_en        = 1'b0;
        w_rd_addr      = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op     = i_in.opcode;
                    n_id     = ID_BITS'(i_in.seq_id);
                    n_handle = HANDLE_BITS'(i_in.payload_handle);
                    n_bytes  = i_in.payload_bytes;
                    n_state  = S_EVAL;
                end
            end

            S_EVAL: begin
                if (w_out_free) begin
                    v_single = 1'b1;
                    unique case (r_op)
                        OP_CHUNK: begin
                            if (r_done) begin
                                v_status = ST_FINISHED;
                            end else if (w_stale) begin
                                v_status = ST_STALE;
                            end else if (w_past) begin
                                v_status = ST_PAST_STOP;
                            end else if (w_oow) begin
                                v_status = ST_OUT_OF_WIN;
                            end else if (w_dup) begin
                                v_status = ST_DUPLICATE;
                            end else begin
                                v_status = ST_ACCEPTED;
                                v_insert = 1'b1;
                            end
                            if (v_insert) begin
                                w_wr_en = 1'b1;
                                n_slot_valid[w_ins_slot] = 1'b1;
                            end
                            // Start the release pass at the head slot.
                            if (!r_done) begin
                                if (w_stop_hit0) begin
                                    n_done       = 1'b1;
                                    n_slot_valid = '0;
                                end else if (n_slot_valid[r_head]) begin
                                    w_rd_en  = 1'b1;
                                    n_fwd    = v_insert && (w_ins_slot == r_head);
                                    n_cnt    = '0;
                                    n_status = v_status;
                                    v_single = 1'b0;
                                    n_state  = S_REL;
                                end
                            end
                        end
                        OP_STOP: begin
                            if (r_stop_set && (r_stop_id < r_id)) begin
                                v_status = ST_STOP_IGNORED;
                            end else if (r_id <= r_next_id) begin
                                n_stop_id    = r_next_id;
                                n_stop_set   = 1'b1;
                                n_done       = 1'b1;
                                n_slot_valid = '0;
                                v_status     = ST_STOP_NOW;
                            end else begin
                                n_stop_id    = r_id;
                                n_stop_set   = 1'b1;
                                n_slot_valid = r_slot_valid & ~w_purge;
                                v_status     = ST_STOP_LATER;
                            end
                        end
                        OP_CANCEL: begin
                            n_done       = 1'b1;
                            n_slot_valid = '0;
                            v_status     = ST_CANCELLED;
                        end
                        default: begin
                            v_status = ST_STOP_IGNORED;
                        end
                    endcase

                    // Items that release nothing give one status-only result.
                    if (v_single) begin
                        n_out_valid    = 1'b1;
                        n_out_has      = 1'b0;
                        n_out_id       = '0;
                        n_out_handle   = '0;
                        n_out_bytes    = '0;
                        n_out_status   = v_status;
                        n_out_finished = n_done;
                        n_out_last     = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end

            S_REL: begin
                if (w_out_free) begin
                    // Transfer the head chunk and advance the window.
                    n_out_valid    = 1'b1;
                    n_out_has      = 1'b1;
                    n_out_id       = ID_W'(r_next_id);
                    n_out_handle   = PAYLOAD_W'(w_rel_data[MEM_W-1:PAYLOAD_W]);
                    n_out_bytes    = w_rel_data[PAYLOAD_W-1:0];
                    n_out_status   = r_status;
                    n_out_finished = r_done;
                    n_out_last     = 1'b1;
                    n_slot_valid[r_head] = 1'b0;
                    n_next_id      = w_next_inc;
                    n_head         = w_head_next;
                    n_fwd          = 1'b0;
                    if (w_stop_hit1) begin
                        n_done       = 1'b1;
                        n_slot_valid = '0;
                        n_state      = S_IDLE;
                    end else if ((r_cnt == CNT_BITS'(MAX_RELEASE - 1)) ||
                                 !n_slot_valid[w_head_next]) begin
                        n_state = S_IDLE;
                    end else begin
                        n_out_last = 1'b0;
                        w_rd_en    = 1'b1;
                        w_rd_addr  = w_head_next;
                        n_cnt      = r_cnt + CNT_BITS'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_id    <= '0;
            r_head       <= '0;
            r_stop_id    <= '0;
            r_stop_set   <= 1'b0;
            r_done       <= 1'b0;
            r_slot_valid <= '0;
            r_fwd        <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_id    <= n_next_id;
            r_head       <= n_head;
            r_stop_id    <= n_stop_id;
            r_stop_set   <= n_stop_set;
            r_done       <= n_done;
            r_slot_valid <= n_slot_valid;
            r_fwd        <= n_fwd;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_id           <= n_id;
        r_handle       <= n_handle;
        r_bytes        <= n_bytes;
        r_status       <= n_status;
        r_out_has      <= n_out_has;
        r_out_id       <= n_out_id;
        r_out_handle   <= n_out_handle;
        r_out_bytes    <= n_out_bytes;
        r_out_status   <= n_out_status;
        r_out_finished <= n_out_finished;
        r_out_last     <= n_out_last;
    end

    // Channel outputs.
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.has_chunk = r_out_has;
    assign o_out.out_id    = r_out_id;
    assign o_out.out_handle = r_out_handle;
    assign o_out.out_bytes = r_out_bytes;
    assign o_out.status    = r_out_status;
    assign o_out.finished  = r_out_finished;
    assign o_out.last      = r_out_last;

    // Once finished, the link stays finished until reset.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag dropped without reset");

    // A finished link holds no stored chunks.
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_slot_valid == '0))
        else $error("stored chunk left after finish");

    // A chunk is only released from a slot that holds one.
    a_release_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REL) && w_out_free) |-> r_slot_valid[r_head])
        else $error("release from an empty slot");

    // A pending stop lies ahead of next_id while the link runs.
    a_stop_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop_set && !r_done) |-> (r_stop_id > r_next_id))
        else $error("stop point passed without finishing");

endmodule

### tb/tb_chunk_reorder_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunk_reorder_window: self-checking bench for the chunk reorder window
// Sends chunk arrivals, stop requests and cancels through the request channel.
// A scoreboard keeps its own copy of the window state and builds the expected
// result transfers for each request. Every result transfer is compared field
// by field. Sender gaps and receiver stalls vary from phase to phase, and one
// long receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_chunk_reorder_window;
    import crw_pkg::*;

    localparam int unsigned CLK_HALF    = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 30;
    localparam int unsigned MAX_GAP     = 8;
    localparam int unsigned PRINT_CAP   = 50;

    // Opcode value that the block does not define.
    localparam logic [OPCODE_W-1:0] OP_UNDEFINED = OPCODE_W'(3);

    // One transfer on the result channel.
    typedef struct packed {
        logic                 has_chunk;
        t_id                  out_id;
        logic [PAYLOAD_W-1:0] out_handle;
        logic [PAYLOAD_W-1:0] out_bytes;
        t_status              status;
        logic                 finished;
        logic                 last;
    } t_result;

    // Scoreboard: tracks the window, predicts the results of every accepted
    // request and checks the result transfers in order.
    class release_scoreboard;
        t_id                    next_seq;
        t_id                    stop_seq;
        bit                     stop_pending;
        bit                     link_done;
        bit                     slot_full [WINDOW];
        bit [HANDLE_BITS-1:0]   slot_handle [WINDOW];
        bit [PAYLOAD_W-1:0]     slot_len [WINDOW];
        t_result                pending_results[$];
        int unsigned            mismatch_count;
        int unsigned            result_count;
        int unsigned            chunk_count;
        bit [15:0]              status_seen;

        function new();
            next_seq       = '0;
            stop_seq       = '0;
            stop_pending   = 1'b0;
            link_done      = 1'b0;
            mismatch_count = 0;
            result_count   = 0;
            chunk_count    = 0;
            status_seen    = '0;
            foreach (slot_full[i]) begin
                slot_full[i]   = 1'b0;
                slot_handle[i] = '0;
                slot_len[i]    = '0;
            end
        endfunction

        task report_mismatch(input string msg);
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endtask

        function void clear_window();
            foreach (slot_full[i]) begin
                slot_full[i] = 1'b0;
            end
        endfunction

        function void add_result(input bit chunk, input t_id id,
                                 input bit [PAYLOAD_W-1:0] hdl,
                                 input bit [PAYLOAD_W-1:0] len, input t_status st);
            t_result r;
            r.has_chunk  = chunk;
            r.out_id     = id;
            r.out_handle = hdl;
            r.out_bytes  = len;
            r.status     = st;
            r.finished   = link_done;
            r.last       = 1'b0;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Finishes the link once the pending stop point has been reached.
        function bit stop_reached();
            if (stop_pending && stop_seq <= next_seq) begin
                link_done = 1'b1;
                clear_window();
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Releases consecutive stored chunks from the head, at most
        // MAX_RELEASE per request.
        function void release_in_order(input t_status st);
            int unsigned n;
            int unsigned s;
            n = 0;
            if (link_done || stop_reached()) begin
                return;
            end
            while (n < MAX_RELEASE) begin
                s = next_seq % WINDOW;
                if (!slot_full[s]) begin
                    break;
                end
                slot_full[s] = 1'b0;
                add_result(1'b1, next_seq, slot_handle[s], slot_len[s], st);
                next_seq = next_seq + 1'b1;
                n++;
                if (stop_reached()) begin
                    break;
                end
            end
        endfunction

        // Called for every accepted request.
        function void note_request(input logic [OPCODE_W-1:0] op, input t_id id,
                                   input logic [PAYLOAD_W-1:0] hdl,
                                   input logic [PAYLOAD_W-1:0] len);
            int unsigned      first;
            int unsigned      s;
            int unsigned      base_slot;
            logic [63:0]      held;
            t_status          st;
            first = pending_results.size();
            s     = id % WINDOW;
            case (op)
                OP_CHUNK: begin
                    if (link_done) begin
                        st = ST_FINISHED;
                    end else if (id < next_seq) begin
                        st = ST_STALE;
                    end else if (stop_pending && id >= stop_seq) begin
                        st = ST_PAST_STOP;
                    end else if (id - next_seq >= WINDOW) begin
                        st = ST_OUT_OF_WIN;
                    end else if (slot_full[s]) begin
                        st = ST_DUPLICATE;
                    end else begin
                        slot_full[s]   = 1'b1;
                        slot_handle[s] = hdl[HANDLE_BITS-1:0];
                        slot_len[s]    = len;
                        st             = ST_ACCEPTED;
                    end
                    release_in_order(st);
                end
                OP_STOP: begin
                    if (stop_pending && stop_seq < id) begin
                        st = ST_STOP_IGNORED;
                    end else if (id <= next_seq) begin
                        stop_seq     = next_seq;
                        stop_pending = 1'b1;
                        link_done    = 1'b1;
                        clear_window();
                        st           = ST_STOP_NOW;
                    end else begin
                        // Drop every stored chunk at or beyond the new stop id.
                        base_slot    = next_seq % WINDOW;
                        stop_seq     = id;
                        stop_pending = 1'b1;
                        for (int unsigned i = 0; i < WINDOW; i++) begin
                            held = 64'(next_seq) + 64'((i + WINDOW - base_slot) % WINDOW);
                            if (held >= 64'(id)) begin
                                slot_full[i] = 1'b0;
                            end
                        end
                        st = ST_STOP_LATER;
                    end
                end
                OP_CANCEL: begin
                    link_done = 1'b1;
                    clear_window();
                    st        = ST_CANCELLED;
                end
                default: begin
                    st = ST_STOP_IGNORED;
                end
            endcase
            if (pending_results.size() == first) begin
                add_result(1'b0, '0, '0, '0, st);
            end
            pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        task compare_field(input string name, input logic [63:0] got,
                           input logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                          result_count, name, got, want));
            end
        endtask

        // Called for every result transfer.
        task check_result(input t_result got);
            t_result want;
            result_count++;
            if (got.has_chunk === 1'b1) begin
                chunk_count++;
            end
            if (!$isunknown(got.status)) begin
                status_seen[got.status] = 1'b1;
            end
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected (id %0d, status %0d)",
                                          result_count, got.out_id, got.status));
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            compare_field("has_chunk",  64'(got.has_chunk),  64'(want.has_chunk));
            compare_field("out_id",     64'(got.out_id),     64'(want.out_id));
            compare_field("out_handle", 64'(got.out_handle), 64'(want.out_handle));
            compare_field("out_bytes",  64'(got.out_bytes),  64'(want.out_bytes));
            compare_field("status",     64'(got.status),     64'(want.status));
            compare_field("finished",   64'(got.finished),   64'(want.finished));
            compare_field("last",       64'(got.last),       64'(want.last));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              hold_active = 1'b0;
    int unsigned       idle_pct    = 0;
    int unsigned       stall_pct   = 0;
    int unsigned       sent_count  = 0;
    int unsigned       cycle_count = 0;
    release_scoreboard sb;

    crw_in_if  in_ch ();
    crw_out_if out_ch ();

    chunk_reorder_window u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // Receiver: random stalls, or a held-off output during the pressure phase.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_active) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Result monitor: every result transfer goes to the scoreboard.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.has_chunk  = out_ch.has_chunk;
            got.out_id     = out_ch.out_id;
            got.out_handle = out_ch.out_handle;
            got.out_bytes  = out_ch.out_bytes;
            got.status     = t_status'(out_ch.status);
            got.finished   = out_ch.finished;
            got.last       = out_ch.last;
            sb.check_result(got);
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PAYLOAD_W'($urandom);
        endcase
    endfunction

    // Offers one request, with a random gap first, and waits for its transfer.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input t_id id,
                                input logic [PAYLOAD_W-1:0] hdl,
                                input logic [PAYLOAD_W-1:0] len);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= op;
        in_ch.seq_id         <= id;
        in_ch.payload_handle <= hdl;
        in_ch.payload_bytes  <= len;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        sb.note_request(op, id, hdl, len);
        sent_count++;
    endtask

    task automatic send_chunk(input t_id id);
        send_request(OP_CHUNK, id, pick_payload(), pick_payload());
    endtask

    // Sends the ids head .. head+count-1 in a shuffled order.
    task automatic send_shuffled_run(input int unsigned count);
        t_id         ids[$];
        t_id         tmp;
        int unsigned j;
        for (int unsigned k = 0; k < count; k++) begin
            ids.insert(ids.size(), sb.next_seq + k);
        end
        for (int unsigned k = count - 1; k > 0; k--) begin
            j      = $urandom_range(k);
            tmp    = ids[k];
            ids[k] = ids[j];
            ids[j] = tmp;
        end
        foreach (ids[k]) begin
            send_chunk(ids[k]);
        end
    endtask

    // Ids for single arrivals: inside the window, the head, stale, just
    // beyond the window, or anywhere in the id space.
    function automatic t_id pick_noise_id();
        t_id head;
        head = sb.next_seq;
        case ($urandom_range(4))
            0: return head + $urandom_range(WINDOW - 1);
            1: return (head == 0) ? head : head - $urandom_range(1, (head < 40) ? head : 40);
            2: return head + WINDOW + $urandom_range(20);
            3: return t_id'($urandom);
            default: return head;
        endcase
    endfunction

    // Opening sequence from reset: release, stale, window edges, duplicate,
    // undefined opcode and a full release of sixteen chunks.
    task automatic run_directed();
        send_request(OP_CHUNK, t_id'(1), '1, '0);
        send_request(OP_CHUNK, t_id'(0), '0, '1);
        send_chunk(t_id'(0));
        send_chunk(t_id'(2 + WINDOW));
        send_chunk(t_id'(1 + WINDOW));
        send_chunk(t_id'(1 + WINDOW));
        send_chunk('1);
        send_request(OP_UNDEFINED, t_id'(5), pick_payload(), pick_payload());
        for (int k = WINDOW; k >= 3; k--) begin
            send_chunk(t_id'(k));
        end
        send_chunk(t_id'(2));
    endtask

    // Mostly shuffled runs of consecutive ids, the rest single arrivals.
    task automatic run_phase(input int unsigned idle, input int unsigned stall);
        int unsigned start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = sent_count;
        while (sent_count - start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 60) begin
                send_shuffled_run($urandom_range(1, WINDOW));
            end else begin
                send_chunk(pick_noise_id());
            end
        end
    endtask

    task automatic hold_receiver(input int unsigned cycles);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_active <= 1'b0;
    endtask

    // Closing sequence: stop handling, finishing at the stop point, and the
    // requests that follow a finished link. The link cannot be reopened
    // without a reset, so this part comes last.
    task automatic run_finale();
        t_id head;
        head = sb.next_seq;
        send_chunk(head + 5);
        send_chunk(head + 9);
        send_chunk(head + 12);
        // Stop later than the head purges the two chunks beyond it.
        send_request(OP_STOP, head + 8, pick_payload(), pick_payload());
        send_request(OP_STOP, head + 20, pick_payload(), pick_payload());
        send_chunk(head + 9);
        send_chunk(head + 8);
        // A lower stop id replaces the pending one.
        send_request(OP_STOP, head + 7, pick_payload(), pick_payload());
        send_chunk(head + 5);
        for (int k = 6; k >= 1; k--) begin
            if (k != 5) begin
                send_chunk(head + k);
            end
        end
        // The head releases up to the stop point and the link finishes.
        send_chunk(head);
        send_chunk(head + 3);
        send_request(OP_UNDEFINED, t_id'($urandom), pick_payload(), pick_payload());
        send_request(OP_STOP, '0, pick_payload(), pick_payload());
        send_request(OP_STOP, '1, pick_payload(), pick_payload());
        send_request(OP_CANCEL, t_id'($urandom), pick_payload(), pick_payload());
        send_chunk(t_id'($urandom));
    endtask

    // Main sequence.
    initial begin
        int unsigned waited;
        sb = new();
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.opcode         <= OP_CHUNK;
        in_ch.seq_id         <= '0;
        in_ch.payload_handle <= '0;
        in_ch.payload_bytes  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(0, 0);

        // Receiver held off while the sender keeps offering chunks.
        idle_pct  = 0;
        stall_pct = 0;
        fork
            hold_receiver(HOLD_CYCLES);
            begin
                send_shuffled_run(WINDOW);
                send_shuffled_run(8);
            end
        join

        run_phase(45, 0);
        run_phase(0, 45);
        run_phase(34, 34);
        run_finale();
        in_ch.valid <= 1'b0;

        // Drain the outstanding results, then watch for stray transfers.
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.pending_results.size()));
        end

        $display("Run covered %0d requests and %0d result transfers, %0d of them chunks.",
                 sent_count, sb.result_count, sb.chunk_count);
        $display("Status codes seen (bit per code): %b, mismatches: %0d.",
                 sb.status_seen[9:0], sb.mismatch_count);
        if (sb.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### chunk_reorder_window.f
sv/crw_pkg.sv
sv/crw_if.sv
sv/crw_ram.sv
sv/chunk_reorder_window.sv
tb/tb_chunk_reorder_window.sv
